### src/rpcm_pkg.sv
// ----------------------------------------------------------------------------
// Read pair consensus merge package
// Shared widths, character codes and types for the consensus merge block.
// ----------------------------------------------------------------------------
package rpcm_pkg;

  localparam int unsigned CharW   = 8;
  localparam int unsigned OffsetW = 7;
  localparam int unsigned CountW  = 11;
  localparam int unsigned TotalW  = 12;
  localparam int unsigned CfgIdxW = 1;

  localparam logic [CharW-1:0] CHAR_N     = 8'h4E;
  localparam logic [CharW-1:0] CHAR_C     = 8'h43;
  localparam logic [CharW-1:0] CHAR_G     = 8'h47;
  localparam logic [CharW-1:0] CHAR_T     = 8'h54;
  localparam logic [CharW-1:0] CHAR_A     = 8'h41;
  localparam logic [CharW-1:0] CHAR_LC_A  = 8'h61;
  localparam logic [CharW-1:0] CHAR_LC_Z  = 8'h7A;
  localparam logic [CharW-1:0] CASE_DELTA = 8'h20;

  localparam logic signed [10:0] QUAL_CAP = 11'sd40;

  localparam logic [CountW-1:0] COUNT_MAX = {CountW{1'b1}};

  localparam logic [CfgIdxW-1:0] CFG_QUAL_OFFSET_IN  = 1'b0;
  localparam logic [CfgIdxW-1:0] CFG_QUAL_OFFSET_OUT = 1'b1;

  localparam logic [OffsetW-1:0] OFFSET_RESET = 7'd33;

  typedef struct packed {
    logic unknown;
    logic mismatch;
  } pair_class_t;

endpackage

### src/read_pair_consensus_merge.sv
// ----------------------------------------------------------------------------
// Read pair consensus merge
// Top level: input register, merge logic, read statistics, result register.
// ----------------------------------------------------------------------------
// The block takes one aligned base pair per cycle while the output side is not
// stalling and returns one consensus base, quality and running mismatch total
// per pair, registered first in the input register and then in the result
// register. The pair counters update as an item moves from the input register
// into the result register, so one pair per clock is sustained while the
// output side keeps taking transfers. Offset registers must be written only
// while the block is empty.
module read_pair_consensus_merge (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [rpcm_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [rpcm_pkg::OffsetW-1:0] cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [rpcm_pkg::CharW-1:0]   base_a_i,
  input  logic [rpcm_pkg::CharW-1:0]   qual_a_i,
  input  logic [rpcm_pkg::CharW-1:0]   base_b_i,
  input  logic [rpcm_pkg::CharW-1:0]   qual_b_i,
  input  logic                         bisulfite_mode_i,
  input  logic                         last_in_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [rpcm_pkg::CharW-1:0]   merged_base_o,
  output logic [rpcm_pkg::CharW-1:0]   merged_qual_o,
  output logic [rpcm_pkg::TotalW-1:0]  mismatch_total_o,
  output logic                         last_out_o
);

  logic [rpcm_pkg::OffsetW-1:0] offset_in_q;
  logic [rpcm_pkg::OffsetW-1:0] offset_out_q;

  logic                       in_valid_q;
  logic [rpcm_pkg::CharW-1:0] base_a_q;
  logic [rpcm_pkg::CharW-1:0] qual_a_q;
  logic [rpcm_pkg::CharW-1:0] base_b_q;
  logic [rpcm_pkg::CharW-1:0] qual_b_q;
  logic                       bisulfite_q;
  logic                       last_q;

  logic                        out_valid_q;
  logic [rpcm_pkg::CharW-1:0]  merged_base_q;
  logic [rpcm_pkg::CharW-1:0]  merged_qual_q;
  logic [rpcm_pkg::TotalW-1:0] total_q;
  logic                        last_out_q;

  logic [rpcm_pkg::CharW-1:0]  merged_base_w;
  logic [rpcm_pkg::CharW-1:0]  merged_qual_w;
  logic [rpcm_pkg::TotalW-1:0] total_w;
  rpcm_pkg::pair_class_t       pair_class;

  logic out_ready;
  logic advance;
  logic in_xfer;

  assign out_ready  = !out_valid_q || !out_stall_i;
  assign advance    = in_valid_q && out_ready;
  assign in_stall_o = in_valid_q && !out_ready;
  assign in_xfer    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_in_q  <= rpcm_pkg::OFFSET_RESET;
      offset_out_q <= rpcm_pkg::OFFSET_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        rpcm_pkg::CFG_QUAL_OFFSET_IN:  offset_in_q  <= cfg_data_i;
        rpcm_pkg::CFG_QUAL_OFFSET_OUT: offset_out_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (!in_stall_o) begin
        in_valid_q <= in_valid_i;
      end
      if (out_ready) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      base_a_q    <= base_a_i;
      qual_a_q    <= qual_a_i;
      base_b_q    <= base_b_i;
      qual_b_q    <= qual_b_i;
      bisulfite_q <= bisulfite_mode_i;
      last_q      <= last_in_i;
    end
    if (advance) begin
      merged_base_q <= merged_base_w;
      merged_qual_q <= merged_qual_w;
      total_q       <= total_w;
      last_out_q    <= last_q;
    end
  end

  rpcm_base_merge u_base_merge (
    .base_a_i         (base_a_q),
    .qual_a_i         (qual_a_q),
    .base_b_i         (base_b_q),
    .qual_b_i         (qual_b_q),
    .bisulfite_mode_i (bisulfite_q),
    .offset_in_i      (offset_in_q),
    .offset_out_i     (offset_out_q),
    .merged_base_o    (merged_base_w),
    .merged_qual_o    (merged_qual_w),
    .pair_class_o     (pair_class)
  );

  rpcm_read_stats u_read_stats (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .advance_i    (advance),
    .last_i       (last_q),
    .pair_class_i (pair_class),
    .total_o      (total_w)
  );

  assign out_valid_o      = out_valid_q;
  assign merged_base_o    = merged_base_q;
  assign merged_qual_o    = merged_qual_q;
  assign mismatch_total_o = total_q;
  assign last_out_o       = last_out_q;

endmodule

### src/rpcm_base_merge.sv
// ----------------------------------------------------------------------------
// Base merge
// Combinational consensus of one base pair: picks the base and quality and
// classifies the pair as holding an N or as a mismatch.
// ----------------------------------------------------------------------------
module rpcm_base_merge (
  input  logic [rpcm_pkg::CharW-1:0]   base_a_i,
  input  logic [rpcm_pkg::CharW-1:0]   qual_a_i,
  input  logic [rpcm_pkg::CharW-1:0]   base_b_i,
  input  logic [rpcm_pkg::CharW-1:0]   qual_b_i,
  input  logic                         bisulfite_mode_i,
  input  logic [rpcm_pkg::OffsetW-1:0] offset_in_i,
  input  logic [rpcm_pkg::OffsetW-1:0] offset_out_i,
  output logic [rpcm_pkg::CharW-1:0]   merged_base_o,
  output logic [rpcm_pkg::CharW-1:0]   merged_qual_o,
  output rpcm_pkg::pair_class_t        pair_class_o
);

  logic [rpcm_pkg::CharW-1:0] ca;
  logic [rpcm_pkg::CharW-1:0] cb;
  logic [rpcm_pkg::CharW-1:0] off_in_w;
  logic [rpcm_pkg::CharW-1:0] off_out_w;
  logic signed [10:0]         sum_raw;
  logic signed [10:0]         sum_cap;
  logic [rpcm_pkg::CharW-1:0] qual_sum;
  logic [rpcm_pkg::CharW-1:0] qual_pass;
  logic                       a_is_n;
  logic                       b_is_n;
  logic                       converted;

  assign ca = (base_a_i >= rpcm_pkg::CHAR_LC_A && base_a_i <= rpcm_pkg::CHAR_LC_Z)
              ? base_a_i - rpcm_pkg::CASE_DELTA : base_a_i;
  assign cb = (base_b_i >= rpcm_pkg::CHAR_LC_A && base_b_i <= rpcm_pkg::CHAR_LC_Z)
              ? base_b_i - rpcm_pkg::CASE_DELTA : base_b_i;

  assign off_in_w  = {1'b0, offset_in_i};
  assign off_out_w = {1'b0, offset_out_i};

  assign a_is_n = (ca == rpcm_pkg::CHAR_N);
  assign b_is_n = (cb == rpcm_pkg::CHAR_N);

  assign converted = bisulfite_mode_i &&
                     ((ca == rpcm_pkg::CHAR_T && cb == rpcm_pkg::CHAR_C) ||
                      (ca == rpcm_pkg::CHAR_G && cb == rpcm_pkg::CHAR_A));

  assign sum_raw = $signed({3'b000, qual_a_i}) + $signed({3'b000, qual_b_i})
                   - $signed({2'b00, off_in_w, 1'b0});
  assign sum_cap  = (sum_raw > rpcm_pkg::QUAL_CAP) ? rpcm_pkg::QUAL_CAP : sum_raw;
  assign qual_sum = sum_cap[rpcm_pkg::CharW-1:0] + off_out_w;

  assign qual_pass = (b_is_n ? qual_a_i : qual_b_i) - off_in_w + off_out_w;

  always_comb begin
    merged_base_o = cb;
    merged_qual_o = qual_sum;
    pair_class_o  = '0;
    if (a_is_n || b_is_n) begin
      merged_base_o        = b_is_n ? ca : cb;
      merged_qual_o        = qual_pass;
      pair_class_o.unknown = 1'b1;
    end else if (ca == cb) begin
      if (bisulfite_mode_i && (cb == rpcm_pkg::CHAR_C || cb == rpcm_pkg::CHAR_G)) begin
        merged_base_o = cb + rpcm_pkg::CASE_DELTA;
      end
    end else if (converted) begin
      merged_base_o = (cb == rpcm_pkg::CHAR_C) ? rpcm_pkg::CHAR_C : rpcm_pkg::CHAR_G;
    end else begin
      pair_class_o.mismatch = 1'b1;
      if (qual_a_i > qual_b_i) begin
        merged_base_o = ca;
        merged_qual_o = qual_a_i - qual_b_i + off_out_w;
      end else if (qual_a_i < qual_b_i) begin
        merged_base_o = cb;
        merged_qual_o = qual_b_i - qual_a_i + off_out_w;
      end else begin
        merged_base_o = rpcm_pkg::CHAR_N;
        merged_qual_o = off_out_w;
      end
    end
  end

endmodule

### src/rpcm_read_stats.sv
// ----------------------------------------------------------------------------
// Read statistics
// Saturating pair, N and mismatch counters of the current read, and the
// mismatch total, plus the N count on a last pair when over a third had an N.
// ----------------------------------------------------------------------------
module rpcm_read_stats (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         advance_i,
  input  logic                         last_i,
  input  rpcm_pkg::pair_class_t        pair_class_i,
  output logic [rpcm_pkg::TotalW-1:0]  total_o
);

  logic [rpcm_pkg::CountW-1:0] mismatch_q, mismatch_d;
  logic [rpcm_pkg::CountW-1:0] unknown_q, unknown_d;
  logic [rpcm_pkg::CountW-1:0] pair_q, pair_d;
  logic [rpcm_pkg::CountW-1:0] mismatch_new;
  logic [rpcm_pkg::CountW-1:0] unknown_new;
  logic [rpcm_pkg::CountW-1:0] pair_new;
  logic [rpcm_pkg::CountW+1:0] unknown_x3;
  logic                        penalty;

  assign pair_new = (pair_q == rpcm_pkg::COUNT_MAX) ? pair_q : pair_q + 1'b1;
  assign unknown_new = (pair_class_i.unknown && unknown_q != rpcm_pkg::COUNT_MAX)
                       ? unknown_q + 1'b1 : unknown_q;
  assign mismatch_new = (pair_class_i.mismatch && mismatch_q != rpcm_pkg::COUNT_MAX)
                        ? mismatch_q + 1'b1 : mismatch_q;

  assign unknown_x3 = {1'b0, unknown_new, 1'b0} + {2'b00, unknown_new};
  assign penalty    = last_i && (unknown_x3 > {2'b00, pair_new});

  assign total_o = {1'b0, mismatch_new}
                   + (penalty ? {1'b0, unknown_new} : {rpcm_pkg::TotalW{1'b0}});

  always_comb begin
    mismatch_d = mismatch_q;
    unknown_d  = unknown_q;
    pair_d     = pair_q;
    if (advance_i) begin
      if (last_i) begin
        mismatch_d = '0;
        unknown_d  = '0;
        pair_d     = '0;
      end else begin
        mismatch_d = mismatch_new;
        unknown_d  = unknown_new;
        pair_d     = pair_new;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mismatch_q <= '0;
      unknown_q  <= '0;
      pair_q     <= '0;
    end else begin
      mismatch_q <= mismatch_d;
      unknown_q  <= unknown_d;
      pair_q     <= pair_d;
    end
  end

endmodule

### sim/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Read pair consensus merge testbench
// Drives base pairs through the merge block under random idling and a long
// output hold-off, predicts each consensus result with an independent model
// of the merge rules and read counters, and compares every output transfer
// field by field. Covers the merge rules, the end-of-read N penalty and both
// quality offset registers.
// ----------------------------------------------------------------------------
module tb_top;

  typedef struct packed {
    logic [rpcm_pkg::CharW-1:0] base_a;
    logic [rpcm_pkg::CharW-1:0] qual_a;
    logic [rpcm_pkg::CharW-1:0] base_b;
    logic [rpcm_pkg::CharW-1:0] qual_b;
    logic                       bisulfite;
    logic                       last;
  } pair_t;

  typedef struct packed {
    logic [rpcm_pkg::CharW-1:0]  base;
    logic [rpcm_pkg::CharW-1:0]  qual;
    logic [rpcm_pkg::TotalW-1:0] total;
    logic                        last;
  } merge_t;

  logic                          clk_i            = 1'b0;
  logic                          rst_ni           = 1'b0;
  logic                          cfg_we_i         = 1'b0;
  logic [rpcm_pkg::CfgIdxW-1:0]  cfg_index_i      = '0;
  logic [rpcm_pkg::OffsetW-1:0]  cfg_data_i       = '0;
  logic                          in_valid_i       = 1'b0;
  logic                          in_stall_o;
  logic [rpcm_pkg::CharW-1:0]    base_a_i         = '0;
  logic [rpcm_pkg::CharW-1:0]    qual_a_i         = '0;
  logic [rpcm_pkg::CharW-1:0]    base_b_i         = '0;
  logic [rpcm_pkg::CharW-1:0]    qual_b_i         = '0;
  logic                          bisulfite_mode_i = 1'b0;
  logic                          last_in_i        = 1'b0;
  logic                          out_valid_o;
  logic                          out_stall_i      = 1'b1;
  logic [rpcm_pkg::CharW-1:0]    merged_base_o;
  logic [rpcm_pkg::CharW-1:0]    merged_qual_o;
  logic [rpcm_pkg::TotalW-1:0]   mismatch_total_o;
  logic                          last_out_o;

  merge_t merge_q[$];
  merge_t want;
  int     fail_count    = 0;
  int     send_idle_pct = 0;
  int     recv_idle_pct = 0;
  int     hold_left     = 0;
  bit     long_hold_req = 1'b0;

  int off_in  = rpcm_pkg::OFFSET_RESET;
  int off_out = rpcm_pkg::OFFSET_RESET;
  int mism_cnt;
  int unk_cnt;
  int pairs_seen;

  read_pair_consensus_merge dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .base_a_i        (base_a_i),
    .qual_a_i        (qual_a_i),
    .base_b_i        (base_b_i),
    .qual_b_i        (qual_b_i),
    .bisulfite_mode_i(bisulfite_mode_i),
    .last_in_i       (last_in_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .merged_base_o   (merged_base_o),
    .merged_qual_o   (merged_qual_o),
    .mismatch_total_o(mismatch_total_o),
    .last_out_o      (last_out_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("Verification failed");
    $finish;
  end

  function automatic logic [rpcm_pkg::CharW-1:0] to_upper(logic [rpcm_pkg::CharW-1:0] c);
    return (c >= rpcm_pkg::CHAR_LC_A && c <= rpcm_pkg::CHAR_LC_Z)
           ? c - rpcm_pkg::CASE_DELTA : c;
  endfunction

  function automatic int bump(int v);
    return (v < rpcm_pkg::COUNT_MAX) ? v + 1 : int'(rpcm_pkg::COUNT_MAX);
  endfunction

  function automatic logic [rpcm_pkg::CharW-1:0] summed_qual(int qa, int qb);
    int s;
    s = qa + qb - 2 * off_in;
    if (s > rpcm_pkg::QUAL_CAP) s = rpcm_pkg::QUAL_CAP;
    return 8'(s + off_out);
  endfunction

  function automatic merge_t predict_merge(pair_t p);
    logic [rpcm_pkg::CharW-1:0] ca;
    logic [rpcm_pkg::CharW-1:0] cb;
    int                         qa;
    int                         qb;
    merge_t                     r;
    ca = to_upper(p.base_a);
    cb = to_upper(p.base_b);
    qa = p.qual_a;
    qb = p.qual_b;
    pairs_seen = bump(pairs_seen);
    if (ca == rpcm_pkg::CHAR_N || cb == rpcm_pkg::CHAR_N) begin
      r.base = (cb == rpcm_pkg::CHAR_N) ? ca : cb;
      r.qual = 8'(((cb == rpcm_pkg::CHAR_N) ? qa : qb) - off_in + off_out);
      unk_cnt = bump(unk_cnt);
    end else if (ca == cb) begin
      r.base = (p.bisulfite && (cb == rpcm_pkg::CHAR_C || cb == rpcm_pkg::CHAR_G))
               ? cb + rpcm_pkg::CASE_DELTA : cb;
      r.qual = summed_qual(qa, qb);
    end else if (p.bisulfite && ((ca == rpcm_pkg::CHAR_T && cb == rpcm_pkg::CHAR_C) ||
                                 (ca == rpcm_pkg::CHAR_G && cb == rpcm_pkg::CHAR_A))) begin
      r.base = (cb == rpcm_pkg::CHAR_C) ? rpcm_pkg::CHAR_C : rpcm_pkg::CHAR_G;
      r.qual = summed_qual(qa, qb);
    end else begin
      if (qa > qb) begin
        r.base = ca;
        r.qual = 8'(qa - qb + off_out);
      end else if (qa < qb) begin
        r.base = cb;
        r.qual = 8'(qb - qa + off_out);
      end else begin
        r.base = rpcm_pkg::CHAR_N;
        r.qual = 8'(off_out);
      end
      mism_cnt = bump(mism_cnt);
    end
    r.total = 12'(mism_cnt);
    r.last  = p.last;
    if (p.last) begin
      if (3 * unk_cnt > pairs_seen) r.total = 12'(mism_cnt + unk_cnt);
      mism_cnt   = 0;
      unk_cnt    = 0;
      pairs_seen = 0;
    end
    return r;
  endfunction

  function automatic pair_t pair_of(logic [7:0] ba, logic [7:0] qa, logic [7:0] bb,
                                    logic [7:0] qb, logic bs, logic last);
    pair_t p;
    p.base_a    = ba;
    p.qual_a    = qa;
    p.base_b    = bb;
    p.qual_b    = qb;
    p.bisulfite = bs;
    p.last      = last;
    return p;
  endfunction

  function automatic logic [rpcm_pkg::CharW-1:0] random_case(logic [rpcm_pkg::CharW-1:0] c);
    return ($urandom_range(3) == 0) ? (c | rpcm_pkg::CASE_DELTA) : c;
  endfunction

  function automatic logic [rpcm_pkg::CharW-1:0] nucleotide();
    case ($urandom_range(3))
      0:       return random_case(rpcm_pkg::CHAR_A);
      1:       return random_case(rpcm_pkg::CHAR_C);
      2:       return random_case(rpcm_pkg::CHAR_G);
      default: return random_case(rpcm_pkg::CHAR_T);
    endcase
  endfunction

  function automatic logic [rpcm_pkg::CharW-1:0] random_qual();
    if ($urandom_range(99) < 80) return 8'(off_in + $urandom_range(45));
    return 8'($urandom_range(255));
  endfunction

  function automatic pair_t random_pair(int n_pct, logic bs, logic last);
    pair_t p;
    int    pick;
    p = pair_of(nucleotide(), random_qual(), nucleotide(), random_qual(), bs, last);
    if ($urandom_range(9) == 0) p.qual_b = p.qual_a;
    if ($urandom_range(99) < n_pct) begin
      case ($urandom_range(2))
        0:       p.base_a = random_case(rpcm_pkg::CHAR_N);
        1:       p.base_b = random_case(rpcm_pkg::CHAR_N);
        default: begin
          p.base_a = random_case(rpcm_pkg::CHAR_N);
          p.base_b = random_case(rpcm_pkg::CHAR_N);
        end
      endcase
    end else begin
      pick = $urandom_range(99);
      if (pick < 35) begin
        p.base_b = random_case(to_upper(p.base_a));
      end else if (pick < 55) begin
        case ($urandom_range(3))
          0: begin
            p.base_a = random_case(rpcm_pkg::CHAR_T);
            p.base_b = random_case(rpcm_pkg::CHAR_C);
          end
          1: begin
            p.base_a = random_case(rpcm_pkg::CHAR_G);
            p.base_b = random_case(rpcm_pkg::CHAR_A);
          end
          2: begin
            p.base_a = random_case(rpcm_pkg::CHAR_C);
            p.base_b = random_case(rpcm_pkg::CHAR_T);
          end
          default: begin
            p.base_a = random_case(rpcm_pkg::CHAR_A);
            p.base_b = random_case(rpcm_pkg::CHAR_G);
          end
        endcase
      end else if (pick >= 90) begin
        p.base_a = 8'($urandom_range(255));
        p.base_b = ($urandom_range(3) == 0) ? p.base_a : 8'($urandom_range(255));
      end
    end
    return p;
  endfunction

  // All tasks below start and end on a rising clock edge.
  task automatic send_pair(input pair_t p);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i       <= 1'b1;
    base_a_i         <= p.base_a;
    qual_a_i         <= p.qual_a;
    base_b_i         <= p.base_b;
    qual_b_i         <= p.qual_b;
    bisulfite_mode_i <= p.bisulfite;
    last_in_i        <= p.last;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    merge_q.push_back(predict_merge(p));
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (merge_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [rpcm_pkg::CfgIdxW-1:0] idx, input int value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= 7'(value);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == rpcm_pkg::CFG_QUAL_OFFSET_IN) off_in = value & 8'h7F;
    else off_out = value & 8'h7F;
  endtask

  task automatic set_offsets(input int in_value, input int out_value);
    wait_drained();
    write_reg(rpcm_pkg::CFG_QUAL_OFFSET_IN, in_value);
    write_reg(rpcm_pkg::CFG_QUAL_OFFSET_OUT, out_value);
  endtask

  task automatic run_reads(input int n_items);
    int   left;
    int   len;
    int   n_pct;
    logic bs;
    left = n_items;
    while (left > 0) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(1, 200) : $urandom_range(1, 30);
      if (len > left) len = left;
      case ($urandom_range(3))
        0:       n_pct = 0;
        1:       n_pct = 10;
        2:       n_pct = 35;
        default: n_pct = 70;
      endcase
      bs = 1'($urandom_range(1));
      for (int i = 0; i < len; i++) begin
        send_pair(random_pair(n_pct, ($urandom_range(19) == 0) ? ~bs : bs, i == len - 1));
      end
      left -= len;
    end
  endtask

  task automatic test_merge_rules();
    send_pair(pair_of(rpcm_pkg::CHAR_A, 8'd73, rpcm_pkg::CHAR_A, 8'd73, 1'b0, 1'b0));
    send_pair(pair_of(rpcm_pkg::CHAR_A | rpcm_pkg::CASE_DELTA, 8'd35,
                      rpcm_pkg::CHAR_A, 8'd36, 1'b0, 1'b0));
    send_pair(pair_of(rpcm_pkg::CHAR_C | rpcm_pkg::CASE_DELTA, 8'd53,
                      rpcm_pkg::CHAR_C, 8'd53, 1'b1, 1'b0));
    send_pair(pair_of(rpcm_pkg::CHAR_G, 8'd53,
                      rpcm_pkg::CHAR_G | rpcm_pkg::CASE_DELTA, 8'd53, 1'b1, 1'b0));
    send_pair(pair_of(rpcm_pkg::CHAR_C, 8'd53, rpcm_pkg::CHAR_C, 8'd53, 1'b0, 1'b0));
    send_pair(pair_of(rpcm_pkg::CHAR_T, 8'd53, rpcm_pkg::CHAR_C, 8'd50, 1'b1, 1'b0));
    send_pair(pair_of(rpcm_pkg::CHAR_G, 8'd53, rpcm_pkg::CHAR_A, 8'd60, 1'b1, 1'b0));
    send_pair(pair_of(rpcm_pkg::CHAR_C, 8'd53, rpcm_pkg::CHAR_T, 8'd53, 1'b1, 1'b0));
    send_pair(pair_of(rpcm_pkg::CHAR_T, 8'd73, rpcm_pkg::CHAR_C, 8'd53, 1'b0, 1'b0));
    send_pair(pair_of(rpcm_pkg::CHAR_A, 8'h00, rpcm_pkg::CHAR_G, 8'hFF, 1'b0, 1'b0));
    send_pair(pair_of(rpcm_pkg::CHAR_N, 8'd40, rpcm_pkg::CHAR_T, 8'd63, 1'b0, 1'b0));
    send_pair(pair_of(rpcm_pkg::CHAR_G | rpcm_pkg::CASE_DELTA, 8'hFF,
                      rpcm_pkg::CHAR_N | rpcm_pkg::CASE_DELTA, 8'h00, 1'b0, 1'b0));
    send_pair(pair_of(rpcm_pkg::CHAR_N | rpcm_pkg::CASE_DELTA, 8'd33,
                      rpcm_pkg::CHAR_N, 8'd34, 1'b0, 1'b0));
    send_pair(pair_of(8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0));
    send_pair(pair_of(rpcm_pkg::CHAR_LC_Z, 8'd60,
                      rpcm_pkg::CHAR_LC_Z - rpcm_pkg::CASE_DELTA, 8'd45, 1'b1, 1'b0));
    send_pair(pair_of(8'hFF, 8'd53, rpcm_pkg::CHAR_LC_Z + 8'd1, 8'd53, 1'b0, 1'b0));
    send_pair(pair_of(rpcm_pkg::CHAR_LC_A - 8'd1, 8'hFF, 8'h40, 8'hFF, 1'b1, 1'b1));
  endtask

  // The penalty applies only when strictly more than a third of the pairs held an N.
  task automatic test_read_end_penalty();
    send_pair(pair_of(rpcm_pkg::CHAR_N, 8'd53, rpcm_pkg::CHAR_A, 8'd53, 1'b0, 1'b0));
    send_pair(pair_of(rpcm_pkg::CHAR_A, 8'd53, rpcm_pkg::CHAR_N, 8'd53, 1'b0, 1'b0));
    send_pair(pair_of(rpcm_pkg::CHAR_C, 8'd53, rpcm_pkg::CHAR_A, 8'd40, 1'b0, 1'b1));
    send_pair(pair_of(rpcm_pkg::CHAR_N, 8'd53, rpcm_pkg::CHAR_A, 8'd53, 1'b0, 1'b0));
    send_pair(pair_of(rpcm_pkg::CHAR_A, 8'd53, rpcm_pkg::CHAR_A, 8'd53, 1'b0, 1'b0));
    send_pair(pair_of(rpcm_pkg::CHAR_C, 8'd53, rpcm_pkg::CHAR_G, 8'd50, 1'b0, 1'b1));
    send_pair(pair_of(rpcm_pkg::CHAR_N, 8'd53, rpcm_pkg::CHAR_N, 8'd60, 1'b0, 1'b1));
  endtask

  task automatic test_offset_settings();
    set_offsets(0, 0);
    run_reads(60);
    set_offsets(127, 127);
    run_reads(60);
    set_offsets(0, 127);
    run_reads(60);
    set_offsets(127, 0);
    run_reads(60);
    set_offsets(rpcm_pkg::OFFSET_RESET, rpcm_pkg::OFFSET_RESET);
  endtask

  // The output stays stalled while the sender keeps offering, so the block
  // fills and stalls its input; then the sender pauses until all is drained.
  task automatic test_backpressure();
    wait_drained();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    @(negedge clk_i);
    long_hold_req = 1'b1;
    @(posedge clk_i);
    run_reads(40);
    wait_drained();
  endtask

  task automatic test_random_traffic();
    set_offsets($urandom_range(127), $urandom_range(127));
    send_idle_pct = 18;
    recv_idle_pct = 46;
    run_reads(150);
    set_offsets($urandom_range(127), $urandom_range(127));
    send_idle_pct = 46;
    recv_idle_pct = 18;
    run_reads(150);
    set_offsets($urandom_range(127), $urandom_range(127));
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_reads(150);
  endtask

  always @(posedge clk_i) begin
    if (long_hold_req) begin
      hold_left     = 64;
      long_hold_req = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  task automatic check_field(input string name, input int exp_val, input int got_val);
    if (exp_val != got_val) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, exp_val,
               got_val);
      fail_count++;
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (merge_q.size() == 0) begin
        $display("%0t: unexpected transfer, expected none, actual base 0x%0h total %0d",
                 $time, merged_base_o, mismatch_total_o);
        fail_count++;
      end else begin
        want = merge_q.pop_front();
        check_field("merged_base", want.base, merged_base_o);
        check_field("merged_qual", want.qual, merged_qual_o);
        check_field("mismatch_total", want.total, mismatch_total_o);
        check_field("last_out", want.last, last_out_o);
      end
    end
  end

  initial begin
    mism_cnt   = 0;
    unk_cnt    = 0;
    pairs_seen = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send_idle_pct = 18;
    recv_idle_pct = 46;
    test_merge_rules();
    test_read_end_penalty();
    wait_drained();
    test_offset_settings();
    test_backpressure();
    test_random_traffic();
    wait_drained();
    repeat (4) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

### files.f
src/rpcm_pkg.sv
src/rpcm_base_merge.sv
src/rpcm_read_stats.sv
src/read_pair_consensus_merge.sv
sim/tb_top.sv
